FILE: rtl/tree_chained_hash_table_top_macros.svh
// Assertion macros used by the tree-chained hash table RTL.
`ifndef TREE_CHAINED_HASH_TABLE_TOP_MACROS_SVH
`define TREE_CHAINED_HASH_TABLE_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define TCHT_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcht assertion failed");
// next-cycle implication
`define TCHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcht assertion failed");
`else
`define TCHT_ASSERT(label, clk, rst_n, ante, cons)
`define TCHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/tcht_pkg.sv
// Types and constants of the tree-chained hash table.
package tcht_pkg;

    localparam int LINK_W     = 11;
    localparam int PROBE_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [LINK_W-1:0] LINK_NONE = 11'h7FF;

    // slot kinds
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_ROOT  = 2'd1;
    localparam logic [1:0] KIND_MOVED = 2'd2;

    // request kinds
    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    // response status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NULL      = 3'd5;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT  = 2'd1;

    typedef struct packed {
        logic        kind;
        logic [31:0] key;
        logic [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_value;
    } rsp_item_t;

    // one slot of the table
    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       key;
        logic [31:0]       value;
        logic [LINK_W-1:0] left;
        logic [LINK_W-1:0] right;
        logic [LINK_W-1:0] parent;
    } row_t;

    // controller to slot store
    typedef struct packed {
        logic              rd_en;
        logic [LINK_W-1:0] rd_addr;
        logic              wr_en;
        logic [LINK_W-1:0] wr_addr;
        row_t              wr_data;
    } mem_req_t;

endpackage

FILE: rtl/tcht_mem.sv
// Slot store: one write port, one registered read port.
module tcht_mem
    import tcht_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output row_t     rd_data
);

    row_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr[ADDR_W-1:0]] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data <= mem[mem_req.rd_addr[ADDR_W-1:0]];
        end
    end

endmodule

FILE: rtl/tcht_ctrl.sv
// Sequencer: tree walk, slot claim, link patching and result register.
`include "tree_chained_hash_table_top_macros.svh"
module tcht_ctrl
    import tcht_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int IDX_W       = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PROBE_W-1:0]    probe_range,
    input  logic [LINK_W-1:0]     fill_limit,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp,
    output mem_req_t              mem_req,
    input  row_t                  rd_data
);

    localparam logic [LINK_W-1:0] SLOTS_L = LINK_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]  LAST_I  = IDX_W'(TABLE_SLOTS - 1);
    localparam int QN = 6;
    localparam int QI_W = 3;

    // sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_HOME_RD  = 4'd2;
    localparam logic [3:0] S_WALK_EV  = 4'd3;
    localparam logic [3:0] S_CL_PROBE = 4'd4;
    localparam logic [3:0] S_CL_PEV   = 4'd5;
    localparam logic [3:0] S_CL_FH    = 4'd6;
    localparam logic [3:0] S_CL_FEV   = 4'd7;
    localparam logic [3:0] S_CL_WRITE = 4'd8;
    localparam logic [3:0] S_Q_SEL    = 4'd9;
    localparam logic [3:0] S_Q_WR     = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;

    // patch field codes
    localparam logic [2:0] F_LEFT   = 3'd0;
    localparam logic [2:0] F_RIGHT  = 3'd1;
    localparam logic [2:0] F_PARENT = 3'd2;
    localparam logic [2:0] F_PFIX   = 3'd3;
    localparam logic [2:0] F_ROOT   = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [LINK_W-1:0] addr;
        logic [2:0]        fld;
        logic [LINK_W-1:0] val;
    } q_ent_t;

    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [LINK_W-1:0]  fh_reg, fh_next;
    logic [LINK_W-1:0]  count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    rsp_item_t          out_reg, out_next;

    logic               kind_reg, kind_next;
    logic [31:0]        key_reg, key_next;
    logic [31:0]        val_reg, val_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   steps_reg, steps_next;
    logic [LINK_W-1:0]  par_reg, par_next;
    logic [PROBE_W-1:0] probe_i_reg, probe_i_next;
    logic [IDX_W-1:0]   got_reg, got_next;
    row_t               claim_row_reg, claim_row_next;
    logic               claim_move_reg, claim_move_next;
    logic               side_right_reg, side_right_next;
    logic [2:0]         status_reg, status_next;
    logic [31:0]        resval_reg, resval_next;
    q_ent_t             q_reg [QN];
    q_ent_t             q_next [QN];
    logic [QI_W-1:0]    q_idx_reg, q_idx_next;

    logic [IDX_W-1:0]   home;
    logic [LINK_W-1:0]  home_link;
    logic [LINK_W-1:0]  probe_t;
    logic [LINK_W-1:0]  walk_nxt;
    logic               key_eq;
    logic               key_lt;
    row_t               patched;
    q_ent_t             q_cur;

    assign home      = key_reg[IDX_W-1:0];
    assign home_link = LINK_W'(home);
    assign probe_t   = par_reg + LINK_W'(probe_i_reg);
    assign key_eq    = (rd_data.key == key_reg);
    assign key_lt    = (rd_data.key < key_reg);
    assign walk_nxt  = key_lt ? rd_data.right : rd_data.left;
    assign q_cur     = q_reg[q_idx_reg];

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // row after applying the current patch
    always_comb
    begin
        patched = rd_data;
        case (q_cur.fld)
            F_LEFT:   patched.left = q_cur.val;
            F_RIGHT:  patched.right = q_cur.val;
            F_PARENT: patched.parent = q_cur.val;
            F_PFIX:
            begin
                if (rd_data.right == home_link)
                begin
                    patched.right = q_cur.val;
                end
                else
                begin
                    patched.left = q_cur.val;
                end
            end
            F_ROOT:
            begin
                patched.kind   = KIND_ROOT;
                patched.key    = key_reg;
                patched.value  = val_reg;
                patched.left   = LINK_NONE;
                patched.right  = LINK_NONE;
                patched.parent = LINK_NONE;
            end
            default: patched = rd_data;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        fh_next         = fh_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        par_next        = par_reg;
        probe_i_next    = probe_i_reg;
        got_next        = got_reg;
        claim_row_next  = claim_row_reg;
        claim_move_next = claim_move_reg;
        side_right_next = side_right_reg;
        status_next     = status_reg;
        resval_next     = resval_reg;
        q_next          = q_reg;
        q_idx_next      = q_idx_reg;
        mem_req         = '0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr_en          = 1'b1;
                mem_req.wr_addr        = LINK_W'(clr_idx_reg);
                mem_req.wr_data.kind   = KIND_EMPTY;
                mem_req.wr_data.left   = (clr_idx_reg == '0) ? LINK_NONE
                                         : LINK_W'(clr_idx_reg - 1'b1);
                mem_req.wr_data.right  = (clr_idx_reg == LAST_I) ? LINK_NONE
                                         : LINK_W'(clr_idx_reg) + 1'b1;
                mem_req.wr_data.parent = LINK_NONE;
                if (clr_idx_reg == LAST_I)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next   = req.kind;
                    key_next    = req.key;
                    val_next    = req.value;
                    steps_next  = '0;
                    q_idx_next  = '0;
                    resval_next = '0;
                    for (int i = 0; i < QN; i++)
                    begin
                        q_next[i].valid = 1'b0;
                    end
                    if (req.kind == OP_SET && req.value == '0)
                    begin
                        status_next = ST_NULL;
                        state_next  = S_FINISH;
                    end
                    else if (req.kind == OP_SET && (count_reg >= fill_limit ||
                             count_reg >= SLOTS_L || fh_reg >= SLOTS_L))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_HOME_RD;
                    end
                end
            end

            S_HOME_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = home_link;
                cur_next        = home;
                state_next      = S_WALK_EV;
            end

            S_WALK_EV:
            begin
                if (steps_reg == '0 && kind_reg == OP_GET && rd_data.kind != KIND_ROOT)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
                else if (steps_reg == '0 && kind_reg == OP_SET &&
                         rd_data.kind == KIND_EMPTY)
                begin
                    // take the home slot out of the free list and make it a root
                    q_next[0] = '{valid: (rd_data.left < SLOTS_L), addr: rd_data.left,
                                  fld: F_RIGHT, val: rd_data.right};
                    q_next[1] = '{valid: (rd_data.right < SLOTS_L), addr: rd_data.right,
                                  fld: F_LEFT, val: rd_data.left};
                    if (home_link == fh_reg)
                    begin
                        fh_next = rd_data.right;
                    end
                    mem_req.wr_en          = 1'b1;
                    mem_req.wr_addr        = home_link;
                    mem_req.wr_data.kind   = KIND_ROOT;
                    mem_req.wr_data.key    = key_reg;
                    mem_req.wr_data.value  = val_reg;
                    mem_req.wr_data.left   = LINK_NONE;
                    mem_req.wr_data.right  = LINK_NONE;
                    mem_req.wr_data.parent = LINK_NONE;
                    count_next  = count_reg + 1'b1;
                    status_next = ST_INSERTED;
                    state_next  = S_Q_SEL;
                end
                else if (steps_reg == '0 && kind_reg == OP_SET &&
                         rd_data.kind != KIND_ROOT)
                begin
                    // moved entry squats at home: relocate it first
                    claim_row_next      = rd_data;
                    claim_row_next.kind = KIND_MOVED;
                    par_next = (rd_data.parent < SLOTS_L) ? rd_data.parent : home_link;
                    claim_move_next = 1'b1;
                    probe_i_next    = '0;
                    status_next     = ST_INSERTED;
                    state_next      = S_CL_PROBE;
                end
                else if (key_eq)
                begin
                    resval_next = rd_data.value;
                    state_next  = S_FINISH;
                    if (kind_reg == OP_GET)
                    begin
                        status_next = ST_FOUND;
                    end
                    else
                    begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_addr       = LINK_W'(cur_reg);
                        mem_req.wr_data       = rd_data;
                        mem_req.wr_data.value = val_reg;
                        status_next = ST_REPLACED;
                    end
                end
                else if (walk_nxt >= SLOTS_L)
                begin
                    if (kind_reg == OP_GET)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        // new leaf under the current node
                        claim_row_next = '{kind: KIND_MOVED, key: key_reg, value: val_reg,
                                           left: LINK_NONE, right: LINK_NONE,
                                           parent: LINK_W'(cur_reg)};
                        par_next        = LINK_W'(cur_reg);
                        claim_move_next = 1'b0;
                        side_right_next = key_lt;
                        probe_i_next    = '0;
                        status_next     = ST_INSERTED;
                        state_next      = S_CL_PROBE;
                    end
                end
                else if (steps_reg == LAST_I)
                begin
                    // walk guard
                    status_next = (kind_reg == OP_GET) ? ST_NOT_FOUND : ST_FULL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    steps_next      = steps_reg + 1'b1;
                    cur_next        = walk_nxt[IDX_W-1:0];
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = walk_nxt;
                end
            end

            S_CL_PROBE:
            begin
                if (probe_i_reg >= probe_range || probe_t >= SLOTS_L)
                begin
                    state_next = S_CL_FH;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = probe_t;
                    state_next      = S_CL_PEV;
                end
            end

            S_CL_PEV:
            begin
                if (rd_data.kind == KIND_EMPTY)
                begin
                    got_next  = probe_t[IDX_W-1:0];
                    q_next[0] = '{valid: (rd_data.left < SLOTS_L), addr: rd_data.left,
                                  fld: F_RIGHT, val: rd_data.right};
                    q_next[1] = '{valid: (rd_data.right < SLOTS_L), addr: rd_data.right,
                                  fld: F_LEFT, val: rd_data.left};
                    if (probe_t == fh_reg)
                    begin
                        fh_next = rd_data.right;
                    end
                    state_next = S_CL_WRITE;
                end
                else
                begin
                    probe_i_next = probe_i_reg + 1'b1;
                    state_next   = S_CL_PROBE;
                end
            end

            S_CL_FH:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = fh_reg;
                got_next        = fh_reg[IDX_W-1:0];
                state_next      = S_CL_FEV;
            end

            S_CL_FEV:
            begin
                fh_next   = rd_data.right;
                q_next[0] = '{valid: (rd_data.right < SLOTS_L), addr: rd_data.right,
                              fld: F_LEFT, val: LINK_NONE};
                state_next = S_CL_WRITE;
            end

            S_CL_WRITE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = LINK_W'(got_reg);
                mem_req.wr_data = claim_row_reg;
                count_next      = count_reg + 1'b1;
                if (claim_move_reg)
                begin
                    // point the moved entry's neighbors at its new slot
                    q_next[2] = '{valid: (claim_row_reg.left < SLOTS_L),
                                  addr: claim_row_reg.left, fld: F_PARENT,
                                  val: LINK_W'(got_reg)};
                    q_next[3] = '{valid: (claim_row_reg.right < SLOTS_L),
                                  addr: claim_row_reg.right, fld: F_PARENT,
                                  val: LINK_W'(got_reg)};
                    q_next[4] = '{valid: (claim_row_reg.parent < SLOTS_L),
                                  addr: claim_row_reg.parent, fld: F_PFIX,
                                  val: LINK_W'(got_reg)};
                    q_next[5] = '{valid: 1'b1, addr: home_link, fld: F_ROOT,
                                  val: LINK_NONE};
                end
                else
                begin
                    q_next[2] = '{valid: 1'b1, addr: LINK_W'(cur_reg),
                                  fld: side_right_reg ? F_RIGHT : F_LEFT,
                                  val: LINK_W'(got_reg)};
                end
                state_next = S_Q_SEL;
            end

            S_Q_SEL:
            begin
                if (q_idx_reg == QI_W'(QN))
                begin
                    state_next = S_FINISH;
                end
                else if (q_cur.valid)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = q_cur.addr;
                    state_next      = S_Q_WR;
                end
                else
                begin
                    q_idx_next = q_idx_reg + 1'b1;
                end
            end

            S_Q_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = q_cur.addr;
                mem_req.wr_data = patched;
                q_idx_next      = q_idx_reg + 1'b1;
                state_next      = S_Q_SEL;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status       = status_reg;
                    out_next.result_value = resval_reg;
                    state_next            = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            fh_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            fh_reg        <= fh_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        par_reg        <= par_next;
        probe_i_reg    <= probe_i_next;
        got_reg        <= got_next;
        claim_row_reg  <= claim_row_next;
        claim_move_reg <= claim_move_next;
        side_right_reg <= side_right_next;
        status_reg     <= status_next;
        resval_reg     <= resval_next;
        q_reg          <= q_next;
        q_idx_reg      <= q_idx_next;
    end

    `TCHT_ASSERT(a_no_wr_idle, clk, rst_n, state_reg == S_IDLE, !mem_req.wr_en)
    `TCHT_ASSERT(a_count_max, clk, rst_n, 1'b1, count_reg <= SLOTS_L)
    `TCHT_ASSERT(a_one_port_op, clk, rst_n, mem_req.rd_en, !mem_req.wr_en)
    `TCHT_ASSERT_NEXT(a_busy_after_take, clk, rst_n, req_valid && !req_stall, state_reg != S_IDLE)

endmodule

FILE: rtl/tree_chained_hash_table_top.sv
// Tree-chained hash table: config registers, sequencer and slot store.
// A key-value table of TABLE_SLOTS slots, served one request at a time by a
// sequencer around a single slot store (one read, one write per cycle, read
// data registered). After reset the store is swept and no request is taken
// meanwhile; config writes are taken at any time. A get, or a set that
// replaces, walks the tree levels below the home slot. Refused and null sets
// finish without touching the store. An insert into an empty home slot scans
// the six entries of the patch queue and applies up to two of them. A new
// leaf walks the tree, claims a slot and applies up to three patches; a
// relocated moved entry at home claims a slot and applies up to six. The slot
// claim probes up to probe_range slots near the parent, then pops the free
// list when probing fails. All steps share the store's single read and write
// port.
module tree_chained_hash_table_top
    import tcht_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    logic [PROBE_W-1:0] probe_range_reg;
    logic [LINK_W-1:0]  fill_limit_reg;
    mem_req_t           mem_req;
    row_t               rd_data;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_range_reg <= PROBE_W'(4);
            fill_limit_reg  <= LINK_W'(717);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROBE_RANGE: probe_range_reg <= cfg_data[PROBE_W-1:0];
                CFG_FILL_LIMIT:  fill_limit_reg  <= cfg_data[LINK_W-1:0];
                default:         probe_range_reg <= probe_range_reg;
            endcase
        end
    end

    tcht_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .probe_range (probe_range_reg),
        .fill_limit  (fill_limit_reg),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    tcht_mem #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the tree-chained hash table.
`timescale 1ns / 1ps

module tb;
    import tcht_pkg::*;

    localparam int SLOTS = 1024;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_item_t             rsp;

    tree_chained_hash_table_top #(.TABLE_SLOTS(SLOTS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // shadow table state
    logic [1:0]        sh_kind   [SLOTS];
    logic [31:0]       sh_key    [SLOTS];
    logic [31:0]       sh_val    [SLOTS];
    logic [LINK_W-1:0] sh_left   [SLOTS];
    logic [LINK_W-1:0] sh_right  [SLOTS];
    logic [LINK_W-1:0] sh_parent [SLOTS];
    logic [LINK_W-1:0] sh_free;
    int unsigned       sh_count;
    int unsigned       sh_probe;
    int unsigned       sh_limit;

    req_item_t   pending_reqs[$];
    rsp_item_t   expected_rsps[$];
    logic [31:0] used_keys[$];
    int          mismatches;
    int          n_sent;
    int          n_checked;
    int          status_seen[8];
    logic        drive_en;

    function automatic bit link_ok(logic [LINK_W-1:0] l);
        return l < SLOTS;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_kind[i]   = KIND_EMPTY;
            sh_key[i]    = '0;
            sh_val[i]    = '0;
            sh_left[i]   = (i == 0) ? LINK_NONE : LINK_W'(i - 1);
            sh_right[i]  = (i == SLOTS - 1) ? LINK_NONE : LINK_W'(i + 1);
            sh_parent[i] = LINK_NONE;
        end
        sh_free  = '0;
        sh_count = 0;
        sh_probe = 4;
        sh_limit = 717;
    endfunction

    function automatic void free_unlink(logic [LINK_W-1:0] s);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = sh_left[s];
        n = sh_right[s];
        if (link_ok(p)) sh_right[p] = n;
        if (link_ok(n)) sh_left[n] = p;
        if (s == sh_free) sh_free = n;
    endfunction

    // take a slot near par, by probing first and then from the free list
    function automatic logic [LINK_W-1:0] take_slot(logic [31:0] k, logic [31:0] v,
                                                     logic [LINK_W-1:0] par);
        logic [LINK_W-1:0] got;
        int unsigned t;
        got = LINK_NONE;
        for (int unsigned i = 0; i < sh_probe; i++)
        begin
            t = par + i;
            if (t >= SLOTS) break;
            if (sh_kind[t] == KIND_EMPTY)
            begin
                got = LINK_W'(t);
                free_unlink(got);
                break;
            end
        end
        if (got == LINK_NONE)
        begin
            got = sh_free;
            sh_free = sh_right[got];
            if (link_ok(sh_free)) sh_left[sh_free] = LINK_NONE;
        end
        sh_left[got]   = LINK_NONE;
        sh_right[got]  = LINK_NONE;
        sh_parent[got] = par;
        sh_key[got]    = k;
        sh_val[got]    = v;
        sh_kind[got]   = KIND_MOVED;
        sh_count++;
        return got;
    endfunction

    // relocate the moved entry at s and repair the links around it
    function automatic void relocate(logic [LINK_W-1:0] s);
        logic [LINK_W-1:0] par;
        logic [LINK_W-1:0] dst;
        logic [LINK_W-1:0] p;
        par = sh_parent[s];
        if (!link_ok(par)) par = s;
        dst = take_slot(sh_key[s], sh_val[s], par);
        sh_left[dst]   = sh_left[s];
        sh_right[dst]  = sh_right[s];
        sh_parent[dst] = sh_parent[s];
        if (link_ok(sh_left[dst])) sh_parent[sh_left[dst]] = dst;
        if (link_ok(sh_right[dst])) sh_parent[sh_right[dst]] = dst;
        if (link_ok(sh_parent[dst]))
        begin
            p = sh_parent[dst];
            if (sh_right[p] == s) sh_right[p] = dst;
            else sh_left[p] = dst;
        end
    endfunction

    function automatic void make_root(logic [LINK_W-1:0] h, logic [31:0] k, logic [31:0] v);
        sh_key[h]    = k;
        sh_val[h]    = v;
        sh_kind[h]   = KIND_ROOT;
        sh_left[h]   = LINK_NONE;
        sh_right[h]  = LINK_NONE;
        sh_parent[h] = LINK_NONE;
    endfunction

    function automatic rsp_item_t table_set(logic [31:0] k, logic [31:0] v);
        rsp_item_t r;
        logic [LINK_W-1:0] home;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] c;
        r = '0;
        home = LINK_W'(k % SLOTS);
        if (v == 0)
        begin
            r.status = ST_NULL;
            return r;
        end
        r.status = ST_FULL;
        if (sh_count >= sh_limit || sh_count >= SLOTS || !link_ok(sh_free)) return r;
        if (sh_kind[home] == KIND_EMPTY)
        begin
            free_unlink(home);
            make_root(home, k, v);
            sh_count++;
            r.status = ST_INSERTED;
            return r;
        end
        if (sh_kind[home] != KIND_ROOT)
        begin
            relocate(home);
            make_root(home, k, v);
            r.status = ST_INSERTED;
            return r;
        end
        cur = home;
        for (int steps = 0; steps < SLOTS; steps++)
        begin
            if (sh_key[cur] == k)
            begin
                r.status = ST_REPLACED;
                r.result_value = sh_val[cur];
                sh_val[cur] = v;
                return r;
            end
            nxt = (sh_key[cur] < k) ? sh_right[cur] : sh_left[cur];
            if (!link_ok(nxt))
            begin
                c = take_slot(k, v, cur);
                if (sh_key[cur] < k) sh_right[cur] = c;
                else sh_left[cur] = c;
                r.status = ST_INSERTED;
                return r;
            end
            cur = nxt;
        end
        return r;
    endfunction

    function automatic rsp_item_t table_get(logic [31:0] k);
        rsp_item_t r;
        logic [LINK_W-1:0] cur;
        r = '0;
        r.status = ST_NOT_FOUND;
        cur = LINK_W'(k % SLOTS);
        if (sh_kind[cur] != KIND_ROOT) return r;
        for (int steps = 0; steps < SLOTS; steps++)
        begin
            if (sh_key[cur] == k)
            begin
                r.status = ST_FOUND;
                r.result_value = sh_val[cur];
                return r;
            end
            cur = (sh_key[cur] < k) ? sh_right[cur] : sh_left[cur];
            if (!link_ok(cur)) return r;
        end
        return r;
    endfunction

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $display("timeout: sent %0d, checked %0d", n_sent, n_checked);
        $finish;
    end

    // request driver: per-item random gap, payload held while stalled
    int req_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(req.kind == OP_GET ? table_get(req.key)
                                                           : table_set(req.key, req.value));
                n_sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_valid && !req_stall)
                begin
                    req_valid <= 1'b0;
                    req_gap   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
                end
                else if (req_gap > 0)
                    req_gap <= req_gap - 1;
                else if (drive_en && pending_reqs.size() > 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // response monitor and stall generator
    int rsp_hold;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_checked++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d value %h",
                                 rsp.status, rsp.result_value);
                end
                else
                begin
                    rsp_item_t e;
                    e = expected_rsps.pop_front();
                    status_seen[e.status]++;
                    if (rsp.status !== e.status || rsp.result_value !== e.result_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status %0d value %h, got %0d %h",
                                     e.status, e.result_value, rsp.status,
                                     rsp.result_value);
                    end
                end
                rsp_hold <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
                rsp_stall <= 1'b1;
            end
            else if (rsp_hold > 0)
            begin
                rsp_hold  <= rsp_hold - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        if (idx == CFG_PROBE_RANGE) sh_probe = val & 5'h1F;
        else if (idx == CFG_FILL_LIMIT) sh_limit = val & 11'h7FF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_req(logic kind, logic [31:0] k, logic [31:0] v);
        req_item_t it;
        it.kind  = kind;
        it.key   = k;
        it.value = v;
        pending_reqs.push_back(it);
        if (kind == OP_SET && v != 0) used_keys.push_back(k);
    endfunction

    // keys partly clustered on home slots 0 to 63 to grow deep trees and moved entries
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(0, 5))
            0, 1: k = {22'($urandom()), 10'($urandom_range(0, 15))};
            2:    k = {22'($urandom_range(0, 3)), 10'($urandom_range(0, 63))};
            3:    k = (used_keys.size() > 0) ?
                      used_keys[$urandom_range(0, used_keys.size() - 1)] : $urandom();
            default: k = $urandom();
        endcase
        return k;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            add_req($urandom_range(0, 2) == 0 ? OP_GET : OP_SET, pick_key(),
                    $urandom_range(0, 19) == 0 ? 32'h0 : $urandom());
    endtask

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        drive_en  = 1'b0;
        mismatches = 0;
        n_sent    = 0;
        n_checked = 0;
        shadow_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_PROBE_RANGE, 1);
        write_reg(CFG_FILL_LIMIT, 1024);

        // directed: extremes, null value, replace, collisions, moved entry at home
        add_req(OP_GET, 32'h0, 32'h0);
        add_req(OP_SET, 32'h0, 32'h0);
        add_req(OP_SET, 32'h0, 32'hFFFF_FFFF);
        add_req(OP_SET, 32'h0, 32'h1);
        add_req(OP_GET, 32'h0, 32'h0);
        add_req(OP_SET, 32'hFFFF_FFFF, 32'hAAAA_5555);
        add_req(OP_SET, 32'h0000_0400, 32'h5555_AAAA);
        add_req(OP_SET, 32'h0000_0800, 32'h1234_5678);
        add_req(OP_SET, 32'hFFFF_FC00, 32'h8765_4321);
        add_req(OP_SET, 32'h0000_0C00, 32'h0F0F_0F0F);
        add_req(OP_SET, 32'h0000_0001, 32'h0000_0011);
        add_req(OP_SET, 32'h0000_0002, 32'h0000_0022);
        add_req(OP_GET, 32'h0000_0800, 32'h0);
        add_req(OP_GET, 32'h0000_1000, 32'h0);
        add_req(OP_GET, 32'h0000_0003, 32'h0);
        add_req(OP_GET, 32'hFFFF_FFFF, 32'h0);
        add_req(OP_GET, 32'h7FFF_FFFF, 32'h0);
        add_req(OP_SET, 32'hFFFF_FC00, 32'hFFFF_FFFF);
        drive_en = 1'b1;
        wait_drained();

        // phase 1: wide probing
        write_reg(CFG_PROBE_RANGE, 16);
        random_phase(300);
        wait_drained();

        // phase 2: no probing, mid fill limit
        write_reg(CFG_PROBE_RANGE, 0);
        write_reg(CFG_FILL_LIMIT, 400);
        random_phase(300);
        wait_drained();

        // phase 3: fill limit of 1, every non-null set is refused as full
        write_reg(CFG_FILL_LIMIT, 1);
        random_phase(100);
        wait_drained();

        // phase 4: widest probing, fill limit above the table size, more inserts
        write_reg(CFG_PROBE_RANGE, 31);
        write_reg(CFG_FILL_LIMIT, 2047);
        for (int i = 0; i < 432; i++)
            add_req(i % 5 == 0 ? OP_GET : OP_SET,
                    i % 3 == 0 ? pick_key() : $urandom(), $urandom() | 32'h1);
        wait_drained();

        $display("Covered %0d requests, %0d responses checked, %0d mismatches",
                 n_sent, n_checked, mismatches);
        $display("Status counts: ins %0d rep %0d found %0d miss %0d full %0d null %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tcht_pkg.sv
rtl/tcht_mem.sv
rtl/tcht_ctrl.sv
rtl/tree_chained_hash_table_top.sv
dv/tb.sv
